// ===== hdl/fba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

	localparam int unsigned FRAME_W = 12;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned STATUS_W = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SKIP = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

	typedef struct packed {
		logic               operation;
		logic [FRAME_W-1:0] current_frame;
		logic               kernel_only;
		logic               write_access;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame;
		logic                present;
		logic                writable;
		logic                user_mode;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [1:0] {
		MEM_IDLE,
		MEM_CLEAR,
		MEM_SET,
		MEM_RESET_BIT
	} mem_op_t;

	typedef enum logic [1:0] {
		RES_SKIP,
		RES_FREED,
		RES_ALLOC,
		RES_FULL
	} res_kind_t;

	typedef struct packed {
		logic      load_req;
		logic      scan_start;
		logic      scan_run;
		logic      free_rd;
		mem_op_t   mem_op;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic req_op;
		logic req_cur_zero;
		logic free_oor;
		logic scan_hit;
		logic scan_fail;
		logic clr_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== hdl/fba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fba_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 128,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire fba_pkg::stat_t stat,
	output fba_pkg::cmd_t      cmd
);

	import fba_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_PUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		cmd.mem_op = MEM_IDLE;
		cmd.res_kind = RES_SKIP;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.mem_op = MEM_CLEAR;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if ((stat.req_op == OP_ALLOC) != stat.req_cur_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_SKIP;
					state_d = ST_PUSH;
				end else if (stat.req_op == OP_FREE) begin
					state_d = ST_FREE_RD;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_FREE_RD: begin
				if (stat.free_oor) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_FREED;
					state_d = ST_PUSH;
				end else begin
					cmd.free_rd = 1'b1;
					state_d = ST_FREE_WR;
				end
			end
			ST_FREE_WR: begin
				cmd.mem_op = MEM_RESET_BIT;
				cmd.res_load = 1'b1;
				cmd.res_kind = RES_FREED;
				state_d = ST_PUSH;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				priority if (stat.scan_hit) begin
					cmd.mem_op = MEM_SET;
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ALLOC;
					state_d = ST_PUSH;
				end else if (stat.scan_fail) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_FULL;
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			req_stall <= 1'b1;
		end else begin
			state_q <= state_d;
			req_stall <= (state_d != ST_IDLE);
		end
	end

`ifndef SYNTH
	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |-> (state_q == ST_IDLE) && !req_stall)
		else $error("request loaded outside idle");

	a_scan_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !(stat.scan_hit && stat.scan_fail))
		else $error("scan hit and fail together");
`endif

endmodule

`default_nettype wire

// ===== hdl/fba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fba_datapath #(
	parameter int unsigned MAX_FRAMES = 4096,
	parameter int unsigned WORD_BITS  = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [fba_pkg::COUNT_W-1:0]    frame_count,
	input  wire fba_pkg::req_t                  req_data,
	output fba_pkg::rsp_t                       rsp_data,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	input  wire fba_pkg::cmd_t                  cmd,
	output fba_pkg::stat_t                      stat
);

	import fba_pkg::*;

	localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BW   = $clog2(WORD_BITS);
	localparam int unsigned CNTW = $clog2(MAP_WORDS * WORD_BITS + 1);
	localparam int unsigned CMPW = (CNTW > COUNT_W) ? CNTW : COUNT_W;
	localparam int unsigned QW   = (AW > FRAME_W) ? AW : FRAME_W;
	// quotient by reciprocal multiply, exact for every FRAME_W-bit frame number
	localparam int unsigned SH   = FRAME_W + $clog2(WORD_BITS);
	localparam int unsigned RW   = SH + 1;
	localparam int unsigned PW   = FRAME_W + RW;
	localparam longint unsigned RECIP_L =
		((longint'(1) << SH) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS);
	localparam logic [RW-1:0]   RECIP  = RW'(RECIP_L);
	localparam logic [CMPW-1:0] MAX_C  = CMPW'(MAX_FRAMES);
	localparam logic [CMPW-1:0] WB_C   = CMPW'(WORD_BITS);
	localparam logic [6:0]      WB7    = 7'(WORD_BITS);
	localparam logic [AW-1:0]   LAST_W = AW'(MAP_WORDS - 1);

	req_t            req_q;
	logic [QW-1:0]   q_q;
	logic [BW-1:0]   r_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   raddr_q;
	logic [CMPW-1:0] rbase_q;
	logic            vld_s1;
	logic [AW-1:0]   word_s1;
	logic [CMPW-1:0] base_s1;
	rsp_t            res_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	logic [CMPW-1:0]      lim;
	logic [CMPW-1:0]      rem;
	logic                 issue;
	logic [PW-1:0]        prod;
	logic [QW+6:0]        qmul;
	logic [QW+6:0]        cur_ext;
	logic [WORD_BITS-1:0] elig;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] lowbit;
	logic [BW-1:0]        hit_idx;
	logic [CMPW-1:0]      hit_frame;
	rsp_t                 res_d;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	assign lim = ({{(CMPW-COUNT_W){1'b0}}, frame_count} > MAX_C) ? MAX_C
		: CMPW'(frame_count);
	assign issue = (rbase_q < lim);
	assign rem = lim - base_s1;

	assign prod = PW'(req_q.current_frame) * PW'(RECIP);
	assign qmul = (QW+7)'(q_q) * (QW+7)'(WB7);
	assign cur_ext = (QW+7)'(req_q.current_frame);

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			elig[b] = (CMPW'(b) < rem);
		end
	end

	assign cand = ~mem_rdata & elig;
	assign lowbit = cand & (~cand + 1'b1);

	always_comb begin
		hit_idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit_idx = BW'(b);
			end
		end
	end

	assign hit_frame = base_s1 + CMPW'(hit_idx);

	always_comb begin
		res_d = '0;
		unique case (cmd.res_kind)
			RES_SKIP: begin
				res_d.frame = req_q.current_frame;
				res_d.status = STATUS_SKIP;
			end
			RES_FREED: begin
				res_d.status = STATUS_DONE;
			end
			RES_ALLOC: begin
				res_d.frame = hit_frame[FRAME_W-1:0];
				res_d.present = 1'b1;
				res_d.writable = req_q.write_access;
				res_d.user_mode = !req_q.kernel_only;
				res_d.status = STATUS_DONE;
			end
			RES_FULL: begin
				res_d.status = STATUS_FULL;
			end
			default: begin
				res_d.status = STATUS_FULL;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b1;
		mem_waddr = word_s1;
		mem_wdata = mem_rdata | lowbit;
		unique case (cmd.mem_op)
			MEM_IDLE: begin
				mem_we = 1'b0;
			end
			MEM_CLEAR: begin
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			MEM_SET: begin
				mem_waddr = word_s1;
				mem_wdata = mem_rdata | lowbit;
			end
			MEM_RESET_BIT: begin
				mem_waddr = q_q[AW-1:0];
				mem_wdata = mem_rdata & ~(WORD_BITS'(1) << r_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_re = cmd.free_rd || (cmd.scan_run && issue);
	assign mem_raddr = cmd.free_rd ? q_q[AW-1:0] : raddr_q;

	fba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_data;
		end
		q_q <= QW'(prod >> SH);
		r_q <= BW'(cur_ext - qmul);
		if (cmd.res_load) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			raddr_q <= '0;
			rbase_q <= '0;
			vld_s1 <= 1'b0;
			word_s1 <= '0;
			base_s1 <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.mem_op == MEM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.scan_start) begin
				raddr_q <= '0;
				rbase_q <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				if (issue) begin
					raddr_q <= raddr_q + 1'b1;
					rbase_q <= rbase_q + WB_C;
				end
				vld_s1 <= issue;
				word_s1 <= raddr_q;
				base_s1 <= rbase_q;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.req_op = req_q.operation;
	assign stat.req_cur_zero = (req_q.current_frame == '0);
	assign stat.free_oor = !(CMPW'(req_q.current_frame) < MAX_C);
	assign stat.scan_hit = vld_s1 && (cand != '0);
	assign stat.scan_fail = !vld_s1 && !issue;
	assign stat.clr_last = (clr_q == LAST_W);
	assign stat.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp_data = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTH
	a_set_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mem_op == MEM_SET) |-> ($countones(mem_wdata ^ mem_rdata) == 1))
		else $error("allocation must set exactly one free bit");

	a_free_only_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mem_op == MEM_RESET_BIT) |->
			((mem_wdata & ~mem_rdata) == '0) && ($countones(mem_wdata ^ mem_rdata) <= 1))
		else $error("free may only clear one bit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("pending response overwritten");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_kind == RES_ALLOC && cmd.res_load) |-> (hit_frame < lim))
		else $error("allocated frame beyond frame count");
`endif

endmodule

`default_nettype wire

// ===== hdl/frame_bitmap_allocator_top.sv =====
// Channel   Dir  Handshake                 Payload
// req       in   req_valid / req_stall     req_data  (fba_pkg::req_t)
// rsp       out  rsp_valid / rsp_stall     rsp_data  (fba_pkg::rsp_t)
// cfg       in   APB psel/penable/pwrite   paddr[2] selects frame_count at 0x0
//
// One request in flight; a new transaction is taken while the last response waits.
// Allocate: the scan reads one bitmap word per cycle through the RAM read port.
// Free: read-modify-write of one word. No-work requests do not touch the bitmap.
// After reset the bitmap is cleared one word a cycle with req_stall high; config writes
// are taken throughout.
// A stalled response holds the controller before it moves to idle.
`timescale 1ns / 1ps
`default_nettype none

module frame_bitmap_allocator_top #(
	parameter int unsigned MAX_FRAMES = 4096,
	parameter int unsigned WORD_BITS  = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire fba_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output fba_pkg::rsp_t      rsp_data,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	import fba_pkg::*;

	localparam logic REG_FRAME_COUNT = 1'b0;

	logic [COUNT_W-1:0] frame_count_q;
	cmd_t               cmd;
	stat_t              stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_FRAME_COUNT)) begin
			frame_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_FRAME_COUNT) ? 32'(frame_count_q) : '0;

	fba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	fba_datapath #(
		.MAX_FRAMES(MAX_FRAMES),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_count(frame_count_q),
		.req_data   (req_data),
		.rsp_data   (rsp_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

`default_nettype wire
